// ===== rtl/core/dsu_pkg.sv =====
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared constants, types and helpers for the disjoint-set engine.
// ----------------------------------------------------------------------------
package dsu_pkg;

  // node table size and derived widths
  localparam int unsigned NODES  = 1024;
  localparam int unsigned NODE_W = $clog2(NODES);
  localparam int unsigned CNT_W  = $clog2(NODES + 1);

  // word field widths
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned IN_DATA_W  = 24;  // node_a + node_b, padded to bytes
  localparam int unsigned OUT_DATA_W = 24;  // root + group_size, padded to bytes

  // operation codes
  localparam logic FUNC_MERGE = 1'b0;
  localparam logic FUNC_FIND  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_COMP_RD,
    ST_COMP_CHK,
    ST_FIND_END,
    ST_CNT_HI,
    ST_CNT_LO,
    ST_CNT_ADD,
    ST_DONE
  } dsu_state_e;

  // out-of-range index saturates to the last node
  function automatic logic [NODE_W-1:0] clamp_node(logic [IDX_W-1:0] v);
    logic [NODE_W-1:0] r;
    if (32'(v) >= NODES) r = NODE_W'(NODES - 1);
    else                 r = NODE_W'(v);
    return r;
  endfunction

endpackage

// ===== rtl/core/dsu_ram.sv =====
// ----------------------------------------------------------------------------
// dsu_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/disjoint_set_union_find_top.sv =====
// ----------------------------------------------------------------------------
// disjoint_set_union_find_top
// Union-find engine with full path compression over a RAM-resident forest.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one operation per word: tuser = func (0 merge,
//   1 find), tdata = node_a and node_b. Master stream returns one word per
//   operation: root and group_size in tdata, joined flag in tuser.
//   Parent links and set sizes live in two RAMs with registered reads.
//   A find reads its start node, follows the links up to the root and,
//   unless the start node is the root, restarts there and compresses the
//   path to the root; it then ends, looks up the set size and loads the
//   result. A merge walks and compresses for node_a, then for node_b, then
//   looks up the set sizes and adds them when two sets join.
//   The parent RAM read port sets the pace: one link followed per cycle.
//   One operation is in flight at a time; tready is high only when idle.
//   After reset the engine sweeps both RAMs, one node per cycle, writing
//   identity links and sizes of one to all NODES (1024) nodes, tready low.
//   A result is held in an output register; if the receiver stalls, the
//   finished result waits there and the next one waits in the done state.
// ----------------------------------------------------------------------------
module disjoint_set_union_find_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave: tdata [9:0] node_a, [19:10] node_b, [23:20] zero
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [dsu_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // slave: tuser [0] func
  input  logic                              s_axis_tuser_i,
  // master: tdata [9:0] root, [20:10] group_size, [23:21] zero
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [dsu_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // master: tuser [0] joined
  output logic                              m_axis_tuser_o
);

  import dsu_pkg::*;

  dsu_state_e state_q, state_d;

  // operation context
  logic              func_q, func_d;
  logic              phase_q, phase_d;     // 0: finding node_a, 1: node_b
  logic [NODE_W-1:0] nb_q, nb_d;
  logic [NODE_W-1:0] start_q, start_d;     // head of the current walk
  logic [NODE_W-1:0] cur_q, cur_d;         // walk / compression pointer
  logic [NODE_W-1:0] root_q, root_d;       // root of the current walk
  logic [NODE_W-1:0] root_a_q, root_a_d;
  logic [NODE_W-1:0] hi_q, hi_d;           // result root
  logic [NODE_W-1:0] lo_q, lo_d;           // root being absorbed
  logic              joined_q, joined_d;
  logic [CNT_W-1:0]  size_q, size_d;
  logic [NODE_W-1:0] clr_q, clr_d;

  // output register
  logic              m_valid_q, m_valid_d;
  logic [IDX_W-1:0]  m_root_q, m_root_d;
  logic [SIZE_W-1:0] m_size_q, m_size_d;
  logic              m_joined_q, m_joined_d;

  // RAM ports
  logic              p_we, c_we;
  logic [NODE_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  logic [NODE_W-1:0] c_waddr, c_raddr;
  logic [CNT_W-1:0]  c_wdata, c_rdata;

  logic              accept;
  logic              out_free;
  logic [CNT_W-1:0]  sum;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign sum      = size_q + c_rdata;

  dsu_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  dsu_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (clr_q == NODE_W'(NODES - 1)) state_d = ST_IDLE;
      ST_IDLE:     if (accept) state_d = ST_WALK_RD;
      ST_WALK_RD:  state_d = ST_WALK_CHK;
      ST_WALK_CHK: begin
        if (p_rdata == cur_q) begin
          state_d = (start_q == cur_q) ? ST_FIND_END : ST_COMP_RD;
        end
      end
      ST_COMP_RD:  state_d = ST_COMP_CHK;
      ST_COMP_CHK: if (p_rdata == root_q) state_d = ST_FIND_END;
      ST_FIND_END: begin
        if (func_q == FUNC_MERGE && !phase_q) state_d = ST_WALK_RD;
        else                                  state_d = ST_CNT_HI;
      end
      ST_CNT_HI:   state_d = ST_CNT_LO;
      ST_CNT_LO:   state_d = joined_q ? ST_CNT_ADD : ST_DONE;
      ST_CNT_ADD:  state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_CLEAR;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    func_d     = func_q;
    phase_d    = phase_q;
    nb_d       = nb_q;
    start_d    = start_q;
    cur_d      = cur_q;
    root_d     = root_q;
    root_a_d   = root_a_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    joined_d   = joined_q;
    size_d     = size_q;
    clr_d      = clr_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_root_d   = m_root_q;
    m_size_d   = m_size_q;
    m_joined_d = m_joined_q;

    p_we    = 1'b0;
    p_waddr = cur_q;
    p_wdata = root_q;
    p_raddr = cur_q;
    c_we    = 1'b0;
    c_waddr = hi_q;
    c_wdata = sum;
    c_raddr = hi_q;

    s_axis_tready_o = (state_q == ST_IDLE);

    case (state_q)
      ST_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_q;
        p_wdata = clr_q;
        c_we    = 1'b1;
        c_waddr = clr_q;
        c_wdata = CNT_W'(1);
        clr_d   = clr_q + NODE_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          func_d   = s_axis_tuser_i;
          phase_d  = 1'b0;
          start_d  = clamp_node(s_axis_tdata_i[IDX_W-1:0]);
          cur_d    = clamp_node(s_axis_tdata_i[IDX_W-1:0]);
          nb_d     = clamp_node(s_axis_tdata_i[2*IDX_W-1:IDX_W]);
          joined_d = 1'b0;
        end
      end
      ST_WALK_CHK: begin
        // follow one link per cycle: address straight from read data
        p_raddr = p_rdata;
        if (p_rdata == cur_q) begin
          root_d = cur_q;
          cur_d  = start_q;
        end else begin
          cur_d = p_rdata;
        end
      end
      ST_COMP_CHK: begin
        // point this node at the root, move to its old parent
        p_we    = 1'b1;
        p_raddr = p_rdata;
        cur_d   = p_rdata;
      end
      ST_FIND_END: begin
        if (func_q == FUNC_MERGE && !phase_q) begin
          root_a_d = root_q;
          phase_d  = 1'b1;
          start_d  = nb_q;
          cur_d    = nb_q;
        end else if (func_q == FUNC_MERGE && root_a_q != root_q) begin
          hi_d     = (root_a_q > root_q) ? root_a_q : root_q;
          lo_d     = (root_a_q > root_q) ? root_q : root_a_q;
          joined_d = 1'b1;
          p_we     = 1'b1;
          p_waddr  = (root_a_q > root_q) ? root_q : root_a_q;
          p_wdata  = (root_a_q > root_q) ? root_a_q : root_q;
        end else begin
          hi_d = root_q;
        end
      end
      ST_CNT_HI: begin
        c_raddr = hi_q;
      end
      ST_CNT_LO: begin
        c_raddr = lo_q;
        size_d  = c_rdata;
      end
      ST_CNT_ADD: begin
        c_we    = 1'b1;
        c_waddr = hi_q;
        c_wdata = sum;
        size_d  = sum;
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_root_d   = IDX_W'(hi_q);
          m_size_d   = SIZE_W'(size_q);
          m_joined_d = joined_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    phase_q    <= phase_d;
    nb_q       <= nb_d;
    start_q    <= start_d;
    cur_q      <= cur_d;
    root_q     <= root_d;
    root_a_q   <= root_a_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    joined_q   <= joined_d;
    size_q     <= size_d;
    m_root_q   <= m_root_d;
    m_size_q   <= m_size_d;
    m_joined_q <= m_joined_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - IDX_W - SIZE_W)'(0), m_size_q, m_root_q};
  assign m_axis_tuser_o  = m_joined_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready_o)
    else $error("input accepted during RAM clear");

  a_accept_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_WALK_RD))
    else $error("accepted word did not start a walk");

  a_join_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_joined_q) |-> (m_size_q >= SIZE_W'(2)))
    else $error("joined result with set size below two");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside done state");

  a_join_only_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CNT_ADD) |-> (joined_q && func_q == FUNC_MERGE))
    else $error("size add without a merge join");

endmodule
